// ===== rtl/core/ddcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Dead double-column finder package
// Geometry, field widths, register indexes, state codes and the pair tests
// shared by the finder's files.
// ----------------------------------------------------------------------------
package ddcf_pkg;

   // Sensor geometry.
   localparam int LAYERS = 8;
   localparam int COLS   = 1024;
   localparam int ROWS   = 512;

   // Field widths of the channels and registers.
   localparam int LAYER_W   = 3;
   localparam int COL_W     = 10;
   localparam int ROW_W     = 9;
   localparam int OUT_W     = 9;
   localparam int CFG_W     = 9;
   localparam int RATIO_W   = 4;
   localparam int CSR_IDX_W = 2;

   // Column store: one entry per (layer, column).
   localparam int NCOLS  = LAYERS * COLS;
   localparam int ADDR_W = $clog2(NCOLS);
   // Distinct counted rows never exceed ROWS-1 (the top row is not counted).
   localparam int CNT_W  = $clog2(ROWS);
   localparam int ENT_W  = CNT_W + 1;
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int PROD_W = CMP_W + RATIO_W;

   // Query gathers five column counts, one read per cycle.
   localparam int SLOTS  = 5;
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] SLOT_Q  = STEP_W'(0);
   localparam logic [STEP_W-1:0] SLOT_M2 = STEP_W'(1);
   localparam logic [STEP_W-1:0] SLOT_M1 = STEP_W'(2);
   localparam logic [STEP_W-1:0] SLOT_P1 = STEP_W'(3);
   localparam logic [STEP_W-1:0] SLOT_P2 = STEP_W'(4);

   typedef enum logic [0:0] {
      OP_HIT   = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_MAX = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BUSY_MIN = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO    = CSR_IDX_W'(2);

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_HIT_WR  = 7'b0000100,
      ST_PART_RD = 7'b0001000,
      ST_PART_WR = 7'b0010000,
      ST_QRY     = 7'b0100000,
      ST_EVAL    = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [CMP_W-1:0]   dead_max;
      logic [CMP_W-1:0]   busy_min;
      logic [RATIO_W-1:0] ratio;
   } cfg_type;

   // Flat column-store address of a layer and column.
   function automatic logic [ADDR_W-1:0] col_addr(input logic [LAYER_W-1:0] layer,
                                                  input logic [COL_W-1:0] col);
      logic [ADDR_W:0] sum;
      sum = (ADDR_W+1)'(layer) * (ADDR_W+1)'(COLS) + (ADDR_W+1)'(col);
      return sum[ADDR_W-1:0];
   endfunction

   // A count is weak against a neighbor when 10 * count < ratio * neighbor.
   function automatic logic weak_vs(input logic [CMP_W-1:0] c,
                                    input logic [CMP_W-1:0] n,
                                    input logic [RATIO_W-1:0] ratio);
      logic [PROD_W-1:0] lhs;
      logic [PROD_W-1:0] rhs;
      lhs = PROD_W'(c) * PROD_W'(10);
      rhs = PROD_W'(ratio) * PROD_W'(n);
      return lhs < rhs;
   endfunction

   // Pair (a, b) with left neighbor l and right neighbor r.
   function automatic logic pair_dead(input logic [CMP_W-1:0] a,
                                      input logic [CMP_W-1:0] b,
                                      input logic [CMP_W-1:0] l,
                                      input logic [CMP_W-1:0] r,
                                      input logic weak_ok,
                                      input cfg_type cfg);
      logic empty;
      logic faint;
      empty = (a <= cfg.dead_max) && (b <= cfg.dead_max);
      faint = weak_ok && (l > cfg.busy_min) && (r > cfg.busy_min) &&
              weak_vs(a, l, cfg.ratio) && weak_vs(a, r, cfg.ratio) &&
              weak_vs(b, l, cfg.ratio) && weak_vs(b, r, cfg.ratio);
      return empty || faint;
   endfunction

endpackage

// ===== rtl/core/dead_double_column_finder_unit.sv =====
// ----------------------------------------------------------------------------
// Dead double-column finder
// Records pixel hits per layer and column and answers queries whether a
// column belongs to a dead double column.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  ----------------------------------
//  req_      in         req_valid/req_ready opcode, layer, column, row,
//                                           frame_start
//  rsp_      out        rsp_valid/rsp_ready dead, hit_rows (one per query)
//  csr_      in         csr_we              csr_index, csr_wdata
//
//  A hit reads the column entry and the column's bitmap word in its transfer
//  cycle and writes them back in the next; the bitmap word is written only for
//  a new counted row. A duplicate hit then reads and marks the partner column.
//  A query makes five reads of the column store through its single read port,
//  then a capture step and an evaluation step. After reset a clearing pass over
//  all LAYERS*COLS (8192) entries zeroes the column store; no request is taken
//  during it, register writes are. A pending response that is not taken
//  stalls the evaluation step; no request is accepted while it stalls.
//
module dead_double_column_finder_unit
   import ddcf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [0:0]           req_opcode,
   input  logic [LAYER_W-1:0]   req_layer,
   input  logic [COL_W-1:0]     req_column,
   input  logic [ROW_W-1:0]     req_row,
   input  logic                 req_frame_start,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_dead,
   output logic [OUT_W-1:0]     rsp_hit_rows,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   // Control state.
   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [STEP_W-1:0] qstep_ff, qstep_in;

   // Item being worked on.
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               dup_ff, dup_in;
   logic               counted_ff, counted_in;
   logic               part_ok_ff, part_ok_in;
   logic               inrange_ff, inrange_in;
   logic [ADDR_W-1:0]  item_addr_ff, item_addr_in;
   logic [ADDR_W-1:0]  part_addr_ff, part_addr_in;

   // Previous hit for the duplicate check.
   logic [LAYER_W-1:0] prev_layer_ff, prev_layer_in;
   logic [COL_W-1:0]   prev_column_ff, prev_column_in;
   logic [ROW_W-1:0]   prev_row_ff, prev_row_in;
   logic               prev_valid_ff, prev_valid_in;

   // Configuration registers.
   logic [CFG_W-1:0]   dead_max_ff, dead_max_in;
   logic [CFG_W-1:0]   busy_min_ff, busy_min_in;
   logic [RATIO_W-1:0] ratio_ff, ratio_in;

   // Query gather registers.
   logic [CNT_W-1:0] slot_ff [SLOTS];
   logic [CNT_W-1:0] slot_in [SLOTS];
   logic             mark_ff, mark_in;

   // Response register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_dead_ff, rsp_dead_in;
   logic [OUT_W-1:0] rsp_hit_rows_ff, rsp_hit_rows_in;

   // Column store: {dup mark, row count} per layer and column.
   logic              cnt_we, cnt_re;
   logic [ADDR_W-1:0] cnt_waddr, cnt_raddr;
   logic [ENT_W-1:0]  cnt_wdata, cnt_rdata;

   // Hit bitmap: one word of ROWS bits per layer and column. A word is only
   // trusted when the column's count is nonzero; the first counted hit writes
   // the whole word, so the bitmap needs no clearing pass of its own.
   logic              bmp_we, bmp_re;
   logic [ROWS-1:0]   bmp_wdata, bmp_rdata;

   logic              req_fire;
   logic              is_query;
   logic              hit_inrange;
   logic [CNT_W-1:0]  cur_cnt;
   logic [ROWS-1:0]   cur_word;
   logic [ROWS-1:0]   word_sh;
   logic [ROWS-1:0]   row_mask;
   logic              row_seen;
   logic              row_inc;
   logic [COL_W:0]    q_ext;
   logic [COL_W:0]    q_p1;
   logic [COL_W:0]    q_p2;
   logic [COL_W-1:0]  q_col;
   logic              rsp_load;
   logic              lo_weak_ok;
   logic              hi_weak_ok;
   logic              lo_dead;
   logic              hi_dead;
   cfg_type           cfg;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_query  = (req_opcode == OP_QUERY);

   assign hit_inrange = (int'(req_layer) < LAYERS) && (int'(req_column) < COLS);

   assign cfg.dead_max = CMP_W'(dead_max_ff);
   assign cfg.busy_min = CMP_W'(busy_min_ff);
   assign cfg.ratio    = ratio_ff;

   // Read-modify-write of the hit: the bitmap word is ignored while the
   // column count is still zero.
   assign cur_cnt  = cnt_rdata[CNT_W-1:0];
   assign cur_word = (cur_cnt == '0) ? '0 : bmp_rdata;
   assign word_sh  = cur_word >> row_ff;
   assign row_seen = word_sh[0];
   assign row_mask = ROWS'(1) << row_ff;
   assign row_inc  = counted_ff && !row_seen;

   // Neighbor columns of the query, clipped at the right edge. Left columns
   // below zero are gated off in the pair tests, so their read is arbitrary.
   assign q_ext = {1'b0, col_ff};
   assign q_p1  = q_ext + (COL_W+1)'(1);
   assign q_p2  = q_ext + (COL_W+1)'(2);

   always_comb begin
      case (qstep_ff)
         SLOT_M2: q_col = (col_ff >= COL_W'(2)) ? col_ff - COL_W'(2) : '0;
         SLOT_M1: q_col = (col_ff >= COL_W'(1)) ? col_ff - COL_W'(1) : '0;
         SLOT_P1: q_col = (int'(q_p1) >= COLS) ? COL_W'(COLS - 1) : q_p1[COL_W-1:0];
         SLOT_P2: q_col = (int'(q_p2) >= COLS) ? COL_W'(COLS - 1) : q_p2[COL_W-1:0];
         default: q_col = col_ff;
      endcase
   end

   // Pair q-1 is {q-1, q} with neighbors q-2 and q+1; pair q is {q, q+1}
   // with neighbors q-1 and q+2. The ratio test needs both neighbors inside.
   assign lo_weak_ok = (int'(col_ff) >= 2) && (int'(col_ff) + 1 < COLS);
   assign hi_weak_ok = (int'(col_ff) >= 1) && (int'(col_ff) + 2 < COLS);
   assign lo_dead = (col_ff != '0) &&
                    pair_dead(CMP_W'(slot_ff[SLOT_M1]), CMP_W'(slot_ff[SLOT_Q]),
                              CMP_W'(slot_ff[SLOT_M2]), CMP_W'(slot_ff[SLOT_P1]),
                              lo_weak_ok, cfg);
   assign hi_dead = pair_dead(CMP_W'(slot_ff[SLOT_Q]), CMP_W'(slot_ff[SLOT_P1]),
                              CMP_W'(slot_ff[SLOT_M1]), CMP_W'(slot_ff[SLOT_P2]),
                              hi_weak_ok, cfg);

   assign rsp_load = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      qstep_in       = qstep_ff;
      layer_in       = layer_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      dup_in         = dup_ff;
      counted_in     = counted_ff;
      part_ok_in     = part_ok_ff;
      inrange_in     = inrange_ff;
      item_addr_in   = item_addr_ff;
      part_addr_in   = part_addr_ff;
      prev_layer_in  = prev_layer_ff;
      prev_column_in = prev_column_ff;
      prev_row_in    = prev_row_ff;
      prev_valid_in  = prev_valid_ff;
      slot_in        = slot_ff;
      mark_in        = mark_ff;

      cnt_we    = 1'b0;
      cnt_waddr = item_addr_ff;
      cnt_wdata = '0;
      cnt_re    = 1'b0;
      cnt_raddr = col_addr(req_layer, req_column);
      bmp_we    = 1'b0;
      bmp_re    = 1'b0;
      bmp_wdata = cur_word | row_mask;

      unique case (state_ff)
         ST_CLEAR: begin
            cnt_we      = 1'b1;
            cnt_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (int'(clr_addr_ff) == NCOLS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               layer_in     = req_layer;
               col_in       = req_column;
               row_in       = req_row;
               inrange_in   = hit_inrange;
               item_addr_in = col_addr(req_layer, req_column);
               part_addr_in = col_addr(req_layer, req_column ^ COL_W'(1));
               part_ok_in   = int'(req_column ^ COL_W'(1)) < COLS;
               counted_in   = int'(req_row) + 1 < ROWS;
               if (is_query) begin
                  qstep_in = SLOT_M2;
                  if (hit_inrange) begin
                     cnt_re   = 1'b1;
                     state_in = ST_QRY;
                  end else begin
                     state_in = ST_EVAL;
                  end
               end else begin
                  dup_in = prev_valid_ff && !req_frame_start &&
                           (prev_layer_ff == req_layer) &&
                           (prev_column_ff == req_column) &&
                           (prev_row_ff == req_row);
                  prev_layer_in  = req_layer;
                  prev_column_in = req_column;
                  prev_row_in    = req_row;
                  prev_valid_in  = 1'b1;
                  if (hit_inrange) begin
                     cnt_re   = 1'b1;
                     bmp_re   = 1'b1;
                     state_in = ST_HIT_WR;
                  end
               end
            end
         end
         ST_HIT_WR: begin
            cnt_we    = 1'b1;
            cnt_wdata = {cnt_rdata[CNT_W] | dup_ff, cur_cnt + CNT_W'(row_inc)};
            bmp_we    = row_inc;
            state_in  = (dup_ff && part_ok_ff) ? ST_PART_RD : ST_IDLE;
         end
         ST_PART_RD: begin
            cnt_re    = 1'b1;
            cnt_raddr = part_addr_ff;
            state_in  = ST_PART_WR;
         end
         ST_PART_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = part_addr_ff;
            cnt_wdata = {1'b1, cur_cnt};
            state_in  = ST_IDLE;
         end
         ST_QRY: begin
            // Read data belongs to the slot issued in the previous cycle.
            slot_in[qstep_ff - STEP_W'(1)] = cur_cnt;
            if (qstep_ff == STEP_W'(1)) begin
               mark_in = cnt_rdata[CNT_W];
            end
            if (int'(qstep_ff) < SLOTS) begin
               cnt_re    = 1'b1;
               cnt_raddr = col_addr(layer_ff, q_col);
               qstep_in  = qstep_ff + STEP_W'(1);
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: loaded at evaluation, held until its transfer.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_dead_in     = rsp_dead_ff;
      rsp_hit_rows_in = rsp_hit_rows_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         if (inrange_ff) begin
            rsp_dead_in     = mark_ff || lo_dead || hi_dead;
            rsp_hit_rows_in = (CMP_W'(slot_ff[SLOT_Q]) > CMP_W'((2 ** OUT_W) - 1)) ?
                              '1 : OUT_W'(slot_ff[SLOT_Q]);
         end else begin
            rsp_dead_in     = 1'b0;
            rsp_hit_rows_in = '0;
         end
      end
   end

   // Register writes decode the index; unknown indexes are dropped.
   always_comb begin
      dead_max_in = dead_max_ff;
      busy_min_in = busy_min_ff;
      ratio_in    = ratio_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEAD_MAX: dead_max_in = csr_wdata;
            CSR_BUSY_MIN: busy_min_in = csr_wdata;
            CSR_RATIO:    ratio_in    = csr_wdata[RATIO_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         qstep_ff      <= '0;
         prev_layer_ff <= '0;
         prev_column_ff <= '0;
         prev_row_ff   <= '0;
         prev_valid_ff <= 1'b0;
         dead_max_ff   <= CFG_W'(1);
         busy_min_ff   <= CFG_W'(100);
         ratio_ff      <= RATIO_W'(7);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         qstep_ff       <= qstep_in;
         prev_layer_ff  <= prev_layer_in;
         prev_column_ff <= prev_column_in;
         prev_row_ff    <= prev_row_in;
         prev_valid_ff  <= prev_valid_in;
         dead_max_ff    <= dead_max_in;
         busy_min_ff    <= busy_min_in;
         ratio_ff       <= ratio_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff        <= layer_in;
      col_ff          <= col_in;
      row_ff          <= row_in;
      dup_ff          <= dup_in;
      counted_ff      <= counted_in;
      part_ok_ff      <= part_ok_in;
      inrange_ff      <= inrange_in;
      item_addr_ff    <= item_addr_in;
      part_addr_ff    <= part_addr_in;
      slot_ff         <= slot_in;
      mark_ff         <= mark_in;
      rsp_dead_ff     <= rsp_dead_in;
      rsp_hit_rows_ff <= rsp_hit_rows_in;
   end

   ddcf_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NCOLS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cnt_re),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   ddcf_ram #(
      .WIDTH (ROWS),
      .DEPTH (NCOLS)
   ) u_bmp_ram (
      .clock   (clock),
      .wr_en   (bmp_we),
      .wr_addr (item_addr_ff),
      .wr_data (bmp_wdata),
      .rd_en   (bmp_re),
      .rd_addr (cnt_raddr),
      .rd_data (bmp_rdata)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dead     = rsp_dead_ff;
   assign rsp_hit_rows = rsp_hit_rows_ff;

   // A response only appears out of the evaluation step.
   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EVAL))
      else $error("response raised outside evaluation");

   // Reads and writes of the column store never overlap, so no entry can be
   // read while its update is still in flight.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cnt_we && cnt_re))
      else $error("column store read and write in the same cycle");

   // A written row count never exceeds the number of countable rows.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HIT_WR) |-> (cnt_wdata[CNT_W-1:0] <= CNT_W'(ROWS - 1)))
      else $error("row count exceeds the countable rows");

endmodule

// ===== rtl/core/ddcf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ddcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
